/* src/pcm_pkg.sv */
package pcm_pkg;

    localparam int TIME_W    = 48;
    localparam int ENERGY_W  = 24;
    localparam int POS_W     = 20;
    localparam int CNT_W     = 8;
    localparam int SEPT_W    = 7;
    localparam int MODE_W    = 2;
    localparam int PROD_W    = POS_W + ENERGY_W + 1;
    localparam int NUM_W     = PROD_W + 1;
    localparam int MAG_W     = NUM_W - 1;
    localparam int TOT_W     = ENERGY_W + 1;
    localparam int DIV_STEPS = POS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int HALF_DIV  = 2;

    localparam logic [MODE_W-1:0] MODE_CENTROID = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WINNER   = 2'd1;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_MERGE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_MUL_OLD,
        ST_MUL_HIT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } t_axis;

    typedef struct packed {
        logic en;
        logic clr;
    } t_mac_ctl;

endpackage

/* src/pcm_mac.sv */
module pcm_mac
    import pcm_pkg::*;
(
    input  logic                    i_clk,
    input  t_mac_ctl                i_ctl,
    input  logic signed [POS_W-1:0] i_a,
    input  logic [ENERGY_W-1:0]     i_b,
    output logic signed [NUM_W-1:0] o_acc
);

    logic signed [PROD_W-1:0] w_prod;
    logic signed [NUM_W-1:0]  w_prod_ext;
    logic signed [NUM_W-1:0]  r_acc;

    assign w_prod     = i_a * $signed({1'b0, i_b});
    assign w_prod_ext = {w_prod[PROD_W-1], w_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.clr) begin
                r_acc <= w_prod_ext;
            end else begin
                r_acc <= r_acc + w_prod_ext;
            end
        end
    end

    assign o_acc = r_acc;

endmodule

/* src/pcm_div.sv */
module pcm_div
    import pcm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [TOT_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [POS_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TOT_W-1:0]     r_rem;
    logic [POS_W-1:0]     r_low;
    logic [TOT_W-1:0]     r_den;
    logic                 r_neg;

    logic [NUM_W-1:0]     w_abs;
    logic [MAG_W-1:0]     w_mag;
    logic [TOT_W:0]       w_trial;
    logic [TOT_W:0]       w_diff;
    logic                 w_ge;

    assign w_abs   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_mag   = w_abs[MAG_W-1:0];
    assign w_trial = {r_rem, r_low[POS_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    // restoring division, one quotient bit per cycle; quotient fits POS_W bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_rem <= w_ge ? w_diff[TOT_W-1:0] : w_trial[TOT_W-1:0];
            r_low <= {r_low[POS_W-2:0], w_ge};
        end else if (i_start) begin
            r_rem <= w_mag[MAG_W-1:POS_W];
            r_low <= w_mag[POS_W-1:0];
            r_den <= i_den;
            r_neg <= i_num[NUM_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(POS_W'(-r_low)) : $signed(r_low);

endmodule

/* src/pulse_centroid_merger_top.sv */
// Channel   Direction  Handshake               Payload
// hit       in         i_valid / o_stall       i_action .. i_septal_count
// pulse     out        o_valid / i_stall       o_pulse_time .. o_max_septal
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (merge mode)
//
// One item at a time. A start item or a merge outside centroid mode skips the arithmetic;
// a centroid merge works through three axes, each two passes through the shared
// multiply-accumulate and 20 steps of the shared radix-2 divider.
// Reset is synchronous, active low; pulse state and septal count clear,
// Compton and Rayleigh counts go to -1, merge mode to centroid.
// A finished pulse waits in the output register; the block holds until it is free.
module pulse_centroid_merger_top
    import pcm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_action,
    input  logic                     i_last,
    input  logic [TIME_W-1:0]        i_hit_time,
    input  logic [ENERGY_W-1:0]      i_hit_energy,
    input  logic signed [POS_W-1:0]  i_hit_x,
    input  logic signed [POS_W-1:0]  i_hit_y,
    input  logic signed [POS_W-1:0]  i_hit_z,
    input  logic signed [CNT_W-1:0]  i_compton_count,
    input  logic signed [CNT_W-1:0]  i_rayleigh_count,
    input  logic [SEPT_W-1:0]        i_septal_count,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [TIME_W-1:0]        o_pulse_time,
    output logic [ENERGY_W-1:0]      o_pulse_energy,
    output logic signed [POS_W-1:0]  o_pulse_x,
    output logic signed [POS_W-1:0]  o_pulse_y,
    output logic signed [POS_W-1:0]  o_pulse_z,
    output logic signed [CNT_W-1:0]  o_max_compton,
    output logic signed [CNT_W-1:0]  o_max_rayleigh,
    output logic [SEPT_W-1:0]        o_max_septal,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [MODE_W-1:0]        i_cfg_data
);

    t_state r_state, n_state;
    t_axis  r_axis;

    logic [MODE_W-1:0]       r_mode;

    logic                    r_hit_action;
    logic                    r_hit_last;
    logic [TIME_W-1:0]       r_hit_time;
    logic [ENERGY_W-1:0]     r_hit_energy;
    logic signed [POS_W-1:0] r_hit_x, r_hit_y, r_hit_z;
    logic signed [CNT_W-1:0] r_hit_compton, r_hit_rayleigh;
    logic [SEPT_W-1:0]       r_hit_septal;

    logic [TIME_W-1:0]       r_acc_time;
    logic [ENERGY_W-1:0]     r_acc_energy;
    logic signed [POS_W-1:0] r_acc_x, r_acc_y, r_acc_z;
    logic [ENERGY_W-1:0]     r_peak;
    logic signed [CNT_W-1:0] r_acc_compton, r_acc_rayleigh;
    logic [SEPT_W-1:0]       r_acc_septal;

    logic                    r_out_valid;
    logic [TIME_W-1:0]       r_out_time;
    logic [ENERGY_W-1:0]     r_out_energy;
    logic signed [POS_W-1:0] r_out_x, r_out_y, r_out_z;
    logic signed [CNT_W-1:0] r_out_compton, r_out_rayleigh;
    logic [SEPT_W-1:0]       r_out_septal;

    logic                    w_accept;
    logic                    w_out_free;
    logic [TOT_W-1:0]        w_total;
    logic                    w_tot_zero;
    logic [ENERGY_W-1:0]     w_energy_sat;
    logic signed [POS_W-1:0] w_pos, w_p;
    logic signed [POS_W:0]   w_pair_sum;
    logic signed [NUM_W-1:0] w_div_num;
    logic [TOT_W-1:0]        w_div_den;
    logic                    w_div_start;
    logic                    w_div_done;
    logic signed [POS_W-1:0] w_quot;
    logic signed [NUM_W-1:0] w_mac_acc;
    t_mac_ctl                w_mac_ctl;
    logic signed [POS_W-1:0] w_mac_a;
    logic [ENERGY_W-1:0]     w_mac_b;

    assign w_accept    = i_valid && !o_stall;
    assign o_stall     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_stall;

    assign w_total      = {1'b0, r_acc_energy} + {1'b0, r_hit_energy};
    assign w_tot_zero   = (w_total == '0);
    assign w_energy_sat = w_total[TOT_W-1] ? '1 : w_total[ENERGY_W-1:0];

    always_comb begin
        unique case (r_axis)
            AX_X: begin
                w_pos = r_acc_x;
                w_p   = r_hit_x;
            end
            AX_Y: begin
                w_pos = r_acc_y;
                w_p   = r_hit_y;
            end
            AX_Z: begin
                w_pos = r_acc_z;
                w_p   = r_hit_z;
            end
            default: begin
                w_pos = r_acc_z;
                w_p   = r_hit_z;
            end
        endcase
    end

    assign w_pair_sum = {w_pos[POS_W-1], w_pos} + {w_p[POS_W-1], w_p};
    // zero total energy: plain mean through the same divider
    assign w_div_num  = w_tot_zero ? {{(NUM_W-POS_W-1){w_pair_sum[POS_W]}}, w_pair_sum}
                                   : w_mac_acc;
    assign w_div_den  = w_tot_zero ? TOT_W'(HALF_DIV) : w_total;

    pcm_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_mac_ctl),
        .i_a   (w_mac_a),
        .i_b   (w_mac_b),
        .o_acc (w_mac_acc)
    );

    pcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_mac_ctl   = '0;
        w_mac_a     = w_pos;
        w_mac_b     = r_acc_energy;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (r_hit_action == ACT_MERGE && r_mode == MODE_CENTROID) begin
                    n_state = ST_MUL_OLD;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_MUL_OLD: begin
                w_mac_ctl = '{en: 1'b1, clr: 1'b1};
                n_state   = ST_MUL_HIT;
            end
            ST_MUL_HIT: begin
                w_mac_ctl = '{en: 1'b1, clr: 1'b0};
                w_mac_a   = w_p;
                w_mac_b   = r_hit_energy;
                n_state   = ST_DIV_START;
            end
            ST_DIV_START: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_axis == AX_Z) ? ST_FINISH : ST_MUL_OLD;
                end
            end
            ST_FINISH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_hit_last) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit_action   <= i_action;
            r_hit_last     <= i_last;
            r_hit_time     <= i_hit_time;
            r_hit_energy   <= i_hit_energy;
            r_hit_x        <= i_hit_x;
            r_hit_y        <= i_hit_y;
            r_hit_z        <= i_hit_z;
            r_hit_compton  <= i_compton_count;
            r_hit_rayleigh <= i_rayleigh_count;
            r_hit_septal   <= i_septal_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_CENTROID;
            r_axis         <= AX_X;
            r_acc_time     <= '0;
            r_acc_energy   <= '0;
            r_acc_x        <= '0;
            r_acc_y        <= '0;
            r_acc_z        <= '0;
            r_peak         <= '0;
            r_acc_compton  <= '1;
            r_acc_rayleigh <= '1;
            r_acc_septal   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_mode <= i_cfg_data;
            if (w_accept) r_axis <= AX_X;
            if (r_state == ST_DIV_WAIT && w_div_done) begin
                unique case (r_axis)
                    AX_X: begin
                        r_acc_x <= w_quot;
                        r_axis  <= AX_Y;
                    end
                    AX_Y: begin
                        r_acc_y <= w_quot;
                        r_axis  <= AX_Z;
                    end
                    AX_Z:    r_acc_z <= w_quot;
                    default: r_acc_z <= w_quot;
                endcase
            end
            if (r_state == ST_FINISH) begin
                if (r_hit_action == ACT_START) begin
                    r_acc_time     <= r_hit_time;
                    r_acc_energy   <= r_hit_energy;
                    r_acc_x        <= r_hit_x;
                    r_acc_y        <= r_hit_y;
                    r_acc_z        <= r_hit_z;
                    r_peak         <= r_hit_energy;
                    r_acc_compton  <= r_hit_compton;
                    r_acc_rayleigh <= r_hit_rayleigh;
                    r_acc_septal   <= r_hit_septal;
                end else begin
                    if (r_hit_time < r_acc_time) r_acc_time <= r_hit_time;
                    if (r_hit_energy > r_peak) begin
                        r_peak <= r_hit_energy;
                        if (r_mode == MODE_WINNER) begin
                            r_acc_x <= r_hit_x;
                            r_acc_y <= r_hit_y;
                            r_acc_z <= r_hit_z;
                        end
                    end
                    r_acc_energy <= w_energy_sat;
                    if (r_hit_compton > r_acc_compton) r_acc_compton <= r_hit_compton;
                    if (r_hit_rayleigh > r_acc_rayleigh) r_acc_rayleigh <= r_hit_rayleigh;
                    if (r_hit_septal > r_acc_septal) r_acc_septal <= r_hit_septal;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && r_hit_last && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && r_hit_last && w_out_free) begin
            r_out_time     <= r_acc_time;
            r_out_energy   <= r_acc_energy;
            r_out_x        <= r_acc_x;
            r_out_y        <= r_acc_y;
            r_out_z        <= r_acc_z;
            r_out_compton  <= r_acc_compton;
            r_out_rayleigh <= r_acc_rayleigh;
            r_out_septal   <= r_acc_septal;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pulse_time   = r_out_time;
    assign o_pulse_energy = r_out_energy;
    assign o_pulse_x      = r_out_x;
    assign o_pulse_y      = r_out_y;
    assign o_pulse_z      = r_out_z;
    assign o_max_compton  = r_out_compton;
    assign o_max_rayleigh = r_out_rayleigh;
    assign o_max_septal   = r_out_septal;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_EMIT)
        else $error("pulse item raised outside emit");

    a_energy_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_hit_action == ACT_MERGE)
        |=> r_acc_energy >= $past(r_acc_energy))
        else $error("merged energy decreased");

endmodule
